// ===== design/chae_pkg.sv =====
// Shared types and constants for the class hierarchy ancestor engine.
package chae_pkg;

   localparam int DEFAULT_MAX_CLASSES = 64;
   localparam int OP_W                = 3;
   localparam int ERR_W               = 2;
   localparam int EPOCH_W             = 8;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SET  = 3'd1,
      OP_ANC  = 3'd2,
      OP_LCA  = 3'd3,
      OP_LOOP = 3'd4
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE    = 2'd0,
      ERR_FULL    = 2'd1,
      ERR_MISSING = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ANC,
      ST_LCA1,
      ST_LCA2,
      ST_LP0,
      ST_LP
   } state_type;

   // Write strobes from the sequencer to the table storage.
   typedef struct packed {
      logic par_we;
      logic mark_we;
      logic mark_clr;
   } store_ctl_type;

endpackage

// ===== design/class_hierarchy_ancestor_engine_core.sv =====
// Top level: class hierarchy ancestor engine with walk sequencer and result register.
//
// Usage
//   req_* carries one operation per transaction: add class, set parent,
//   ancestor test, least common ancestor, or loop check. rsp_* returns
//   exactly one result transaction per request, in order.
//   Add, set parent, bad operands, loop checks on the root and unknown
//   operations answer in the accept cycle: the result is valid on the next cycle.
//   Walks take one parent-table read per step, one step per cycle; a
//   common ancestor query walks two chains. The single-port table read
//   loop sets the step rate. The block takes one request at a time;
//   req_tready is low while a walk runs.
//   Visit marks are tagged with a query epoch. After reset, and after every
//   255th common ancestor or loop check walk, a clearing pass over all
//   MAX_CLASSES entries rewrites the mark memory; req_tready stays low during it.
//   Reset (synchronous, active high) empties the table (class count zero).
//   A result waits in the output register while rsp_tready is low; a walk
//   that finishes meanwhile holds until the register frees up.
module class_hierarchy_ancestor_engine_core #(
   parameter int MAX_CLASSES = chae_pkg::DEFAULT_MAX_CLASSES,
   localparam int NW          = $clog2(MAX_CLASSES + 1),
   localparam int REQ_W       = chae_pkg::OP_W + 2 * NW,
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8,
   localparam int RSP_W       = NW + 1 + chae_pkg::ERR_W,
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata, low bit up: operation, class_a, class_b, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata, low bit up: class_index, answer_flag, error_code, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(MAX_CLASSES);
   localparam int EW = chae_pkg::EPOCH_W;
   localparam logic [NW-1:0] ROOT      = NW'(MAX_CLASSES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CLASSES - 1);

   chae_pkg::state_type     state_ff, state_in;
   chae_pkg::store_ctl_type ctl;

   logic [NW-1:0]  t_ff, t_in;
   logic [NW-1:0]  steps_ff, steps_in;
   logic [NW-1:0]  b_ff, b_in;
   logic [NW-1:0]  count_ff, count_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic [EW-1:0]  epoch_ff, epoch_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]          rsp_idx_ff, rsp_idx_in;
   logic                   rsp_flag_ff, rsp_flag_in;
   logic [chae_pkg::ERR_W-1:0] rsp_err_ff, rsp_err_in;

   logic [chae_pkg::OP_W-1:0] req_op;
   logic [NW-1:0]  req_a, req_b;
   logic           accept, slot_free, load;
   logic           a_class, a_node, b_node;
   logic [NW-1:0]  res_idx;
   logic           res_flag;
   logic [chae_pkg::ERR_W-1:0] res_err;

   logic [AW-1:0]  rd_addr, par_addr, mark_addr;
   logic [NW-1:0]  par_data;
   logic [NW-1:0]  rd_parent;
   logic           rd_visited;

   assign req_op = req_tdata[chae_pkg::OP_W-1:0];
   assign req_a  = req_tdata[chae_pkg::OP_W +: NW];
   assign req_b  = req_tdata[chae_pkg::OP_W + NW +: NW];

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   assign a_class = req_a < count_ff;
   assign a_node  = a_class || (req_a == ROOT);
   assign b_node  = (req_b < count_ff) || (req_b == ROOT);

   // Read always targets the next walk node, so read data matches t_ff.
   assign rd_addr = (t_in == ROOT) ? '0 : t_in[AW-1:0];

   chae_store #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_store (
      .clock      (clock),
      .ctl        (ctl),
      .rd_addr    (rd_addr),
      .par_addr   (par_addr),
      .par_data   (par_data),
      .mark_addr  (mark_addr),
      .epoch      (epoch_ff),
      .rd_parent  (rd_parent),
      .rd_visited (rd_visited)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chae_pkg::ST_SWEEP;
         count_ff     <= '0;
         sweep_ff     <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      steps_ff    <= steps_in;
      b_ff        <= b_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // Sequencer: next state, store strobes and result capture.
   always_comb begin
      logic finish;
      finish     = 1'b0;
      state_in   = state_ff;
      t_in       = t_ff;
      steps_in   = steps_ff;
      b_in       = b_ff;
      count_in   = count_ff;
      sweep_in   = sweep_ff;
      epoch_in   = epoch_ff;
      ctl        = '0;
      par_addr   = count_ff[AW-1:0];
      par_data   = req_b;
      mark_addr  = t_ff[AW-1:0];
      req_tready = 1'b0;
      load       = 1'b0;
      res_idx    = '0;
      res_flag   = 1'b0;
      res_err    = chae_pkg::ERR_NONE;

      case (state_ff)
         chae_pkg::ST_SWEEP: begin
            ctl.mark_we  = 1'b1;
            ctl.mark_clr = 1'b1;
            mark_addr    = sweep_ff;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               epoch_in = '0;
               state_in = chae_pkg::ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         chae_pkg::ST_IDLE: begin
            req_tready = slot_free;
            if (accept) begin
               case (req_op)
                  chae_pkg::OP_ADD: begin
                     load = 1'b1;
                     if (count_ff == ROOT) begin
                        res_err = chae_pkg::ERR_FULL;
                     end else if (!b_node) begin
                        res_err = chae_pkg::ERR_MISSING;
                     end else begin
                        ctl.par_we = 1'b1;
                        res_idx    = count_ff;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  chae_pkg::OP_SET: begin
                     load     = 1'b1;
                     par_addr = req_a[AW-1:0];
                     if (!a_class || !b_node) begin
                        res_err = chae_pkg::ERR_MISSING;
                     end else begin
                        ctl.par_we = 1'b1;
                     end
                  end
                  chae_pkg::OP_ANC: begin
                     if (!a_node || !b_node) begin
                        load    = 1'b1;
                        res_err = chae_pkg::ERR_MISSING;
                     end else begin
                        t_in     = req_a;
                        b_in     = req_b;
                        steps_in = '0;
                        state_in = chae_pkg::ST_ANC;
                     end
                  end
                  chae_pkg::OP_LCA: begin
                     if (!a_node || !b_node) begin
                        load    = 1'b1;
                        res_err = chae_pkg::ERR_MISSING;
                     end else begin
                        t_in     = req_a;
                        b_in     = req_b;
                        steps_in = '0;
                        epoch_in = epoch_ff + 1'b1;
                        state_in = chae_pkg::ST_LCA1;
                     end
                  end
                  chae_pkg::OP_LOOP: begin
                     if (!a_node) begin
                        load    = 1'b1;
                        res_err = chae_pkg::ERR_MISSING;
                     end else if (req_a == ROOT) begin
                        load = 1'b1;
                     end else begin
                        t_in     = req_a;
                        epoch_in = epoch_ff + 1'b1;
                        state_in = chae_pkg::ST_LP0;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end

         chae_pkg::ST_ANC: begin
            if (t_ff == ROOT) begin
               finish   = 1'b1;
               res_flag = (b_ff == ROOT);
            end else if (t_ff == b_ff) begin
               finish   = 1'b1;
               res_flag = 1'b1;
            end else if (steps_ff == ROOT) begin
               finish = 1'b1;
            end else begin
               t_in     = rd_parent;
               steps_in = steps_ff + 1'b1;
            end
         end

         // First chain: mark every node from class_a up.
         chae_pkg::ST_LCA1: begin
            if (t_ff == ROOT) begin
               t_in     = b_ff;
               steps_in = '0;
               state_in = chae_pkg::ST_LCA2;
            end else begin
               ctl.mark_we = 1'b1;
               if (steps_ff == ROOT) begin
                  t_in     = b_ff;
                  steps_in = '0;
                  state_in = chae_pkg::ST_LCA2;
               end else begin
                  t_in     = rd_parent;
                  steps_in = steps_ff + 1'b1;
               end
            end
         end

         // Second chain: first marked node is the answer, or the root if none is marked.
         chae_pkg::ST_LCA2: begin
            if (t_ff == ROOT) begin
               finish  = 1'b1;
               res_idx = ROOT;
            end else if (rd_visited) begin
               finish  = 1'b1;
               res_idx = t_ff;
            end else if (steps_ff == ROOT) begin
               finish  = 1'b1;
               res_idx = ROOT;
            end else begin
               t_in     = rd_parent;
               steps_in = steps_ff + 1'b1;
            end
         end

         chae_pkg::ST_LP0: begin
            ctl.mark_we = 1'b1;
            t_in        = rd_parent;
            steps_in    = '0;
            state_in    = chae_pkg::ST_LP;
         end

         chae_pkg::ST_LP: begin
            if (t_ff == ROOT) begin
               finish = 1'b1;
            end else if (rd_visited) begin
               finish   = 1'b1;
               res_idx  = t_ff;
               res_flag = 1'b1;
            end else if (steps_ff == ROOT) begin
               // cap ran out: report the node one step past the last one
               finish   = 1'b1;
               res_idx  = rd_parent;
               res_flag = 1'b1;
            end else begin
               ctl.mark_we = 1'b1;
               t_in        = rd_parent;
               steps_in    = steps_ff + 1'b1;
            end
         end

         default: begin
            state_in = chae_pkg::ST_IDLE;
         end
      endcase

      // Walk done: deliver once the result register is free, else hold.
      if (finish && slot_free) begin
         load     = 1'b1;
         state_in = (epoch_ff == '1) ? chae_pkg::ST_SWEEP : chae_pkg::ST_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_err_in   = rsp_err_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = res_idx;
         rsp_flag_in  = res_flag;
         rsp_err_in   = res_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_err_ff, rsp_flag_ff, rsp_idx_ff});

endmodule

// ===== design/chae_store.sv =====
// Parent table and visit-mark memories with registered reads.
module chae_store #(
   parameter int MAX_CLASSES = chae_pkg::DEFAULT_MAX_CLASSES,
   localparam int NW = $clog2(MAX_CLASSES + 1),
   localparam int AW = $clog2(MAX_CLASSES),
   localparam int EW = chae_pkg::EPOCH_W
) (
   input  logic                   clock,
   input  chae_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]          rd_addr,
   input  logic [AW-1:0]          par_addr,
   input  logic [NW-1:0]          par_data,
   input  logic [AW-1:0]          mark_addr,
   input  logic [EW-1:0]          epoch,
   output logic [NW-1:0]          rd_parent,
   output logic                   rd_visited
);

   logic [NW-1:0] parent_mem [MAX_CLASSES];
   logic [EW-1:0] mark_mem   [MAX_CLASSES];
   logic [NW-1:0] par_q_ff;
   logic [EW-1:0] mark_q_ff;
   logic          fwd_ff;
   logic          fwd_in;

   // Mark written this cycle at the address being read: memory returns old data.
   assign fwd_in = ctl.mark_we && !ctl.mark_clr && (mark_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (ctl.par_we) begin
         parent_mem[par_addr] <= par_data;
      end
      par_q_ff <= parent_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.mark_we) begin
         mark_mem[mark_addr] <= ctl.mark_clr ? '0 : epoch;
      end
      mark_q_ff <= mark_mem[rd_addr];
      fwd_ff    <= fwd_in;
   end

   assign rd_parent  = par_q_ff;
   assign rd_visited = fwd_ff || (mark_q_ff == epoch);

endmodule
